// ===== hdl/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants and codes of the spring bone chain step block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  localparam int MAX_BONES = 16;
  localparam int BONE_W    = $clog2(MAX_BONES);
  localparam int COUNT_W   = BONE_W + 1;

  // link length at or below which the direction is not trusted (0.001 in Q16.16)
  localparam logic [31:0] NEAR_ZERO = 32'd66;
  localparam logic [17:0] ONE_Q16   = 18'sd65536;
  localparam logic [17:0] MONE_Q16  = -18'sd65536;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 48;

  // input commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_CAPTURE = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BONE_COUNT = 3'd0;
  localparam logic [2:0] REG_DRAG_GAIN  = 3'd1;
  localparam logic [2:0] REG_GRAVITY_X  = 3'd2;
  localparam logic [2:0] REG_GRAVITY_Y  = 3'd3;
  localparam logic [2:0] REG_GRAVITY_Z  = 3'd4;

  localparam logic [4:0]  BONE_COUNT_RST = 5'd2;
  localparam logic [15:0] DRAG_GAIN_RST  = 16'd16384;
  localparam logic [23:0] GRAVITY_Y_RST  = 24'hF633B3;

  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][17:0] dir3_t;

  typedef struct packed {
    vec3_t cur;
    vec3_t prv;
  } pos_t;

  typedef struct packed {
    logic [31:0] len;
    dir3_t       dir;
  } rest_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAV,
    ST_CAP0,
    ST_CAP1,
    ST_RD,
    ST_VEL,
    ST_DIFF,
    ST_SQ,
    ST_SQRT,
    ST_PICK,
    ST_DIV,
    ST_CON,
    ST_WB
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/sbc_ifs.sv =====
// ----------------------------------------------------------------------------
// sbc channel interfaces
// Command channel and result channel of the spring bone chain step block.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  bone_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [15:0] time_step;

  modport source (output valid, cmd, bone_index, pos_x, pos_y, pos_z, time_step,
                  input ready);
  modport sink (input valid, cmd, bone_index, pos_x, pos_y, pos_z, time_step,
                output ready);
endinterface

interface sbc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  bone_index_res;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        last;

  modport source (output valid, bone_index_res, out_x, out_y, out_z, last,
                  input ready);
  modport sink (input valid, bone_index_res, out_x, out_y, out_z, last,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/spring_bone_chain_step.sv =====
// ----------------------------------------------------------------------------
// spring_bone_chain_step
// Verlet bone chain in Q16.16: load, capture rest shape, simulation step.
// ----------------------------------------------------------------------------
// One command at a time. A capture and a step walk the chain link by link,
// skipping the divider for each link too short to divide; a step also
// waits on any output stall. Per link the square root and the three-lane
// divider dominate. Bone positions live in one memory and rest lengths and
// directions in a second one, each read through a registered output;
// positions are written back once per moved bone on a step, rest entries
// once per link on a capture. A step emits one word per moved bone, root
// excluded, with last set on the final bone.
`default_nettype none

module spring_bone_chain_step import sbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sbc_in_if.sink           in_ch,
  sbc_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // configuration registers
  logic [4:0]       bone_count_r;
  logic [15:0]      drag_gain_r;
  logic [2:0][23:0] grav_r;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  // memories
  pos_t  pm [MAX_BONES];
  rest_t rm [MAX_BONES-1];
  pos_t  pm_q;
  rest_t rm_q;
  logic              pm_we, pm_re;
  logic [BONE_W-1:0] pm_wa, pm_ra, rm_a;
  pos_t              pm_wd;
  logic              rm_we, rm_re;

  // control
  state_t             st_r, st_nxt;
  logic [5:0]         cnt_r;
  logic [2:0]         ph;
  logic [BONE_W-1:0]  bone_r, bone_nxt;
  logic [COUNT_W-1:0] n_r;
  logic               cap_r;
  logic               in_acc, emit, advance, is_last, out_free;

  // datapath
  vec3_t       par_r, nc_r, d_r, g_r;
  dir3_t       u_r;
  logic [15:0] dt_r;
  logic [31:0] dt2_r;
  logic [63:0] sum_r, sv_r, res_r, bit_r;
  logic [31:0] len_r;
  logic [2:0][47:0] num_r;
  logic [2:0][31:0] rem_r;
  logic [2:0]       neg_r;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_r;

  logic [1:0]  lane, plane;
  logic [31:0] vdiff;
  vec3_t       dsrc;

  // sqrt and divider step logic
  logic [63:0] sq_t, sv_n, res_n;
  logic [2:0][32:0] dv_t;
  logic [2:0]       dv_ge;
  logic [2:0][47:0] num_n;
  logic [2:0][31:0] rem_n;

  // out register
  logic        out_valid_r;
  logic [3:0]  out_idx_r;
  vec3_t       out_pos_r;
  logic        out_last_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign ph       = cnt_r[2:0];
  assign lane     = ph[1:0];
  assign plane    = 2'(ph - 3'd1);
  assign is_last  = ({1'b0, bone_r} == n_r - COUNT_W'(1));

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= BONE_COUNT_RST;
      drag_gain_r  <= DRAG_GAIN_RST;
      grav_r[0]    <= '0;
      grav_r[1]    <= GRAVITY_Y_RST;
      grav_r[2]    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BONE_COUNT: bone_count_r <= cfg_pwdata[4:0];
        REG_DRAG_GAIN:  drag_gain_r  <= cfg_pwdata[15:0];
        REG_GRAVITY_X:  grav_r[0]    <= cfg_pwdata[23:0];
        REG_GRAVITY_Y:  grav_r[1]    <= cfg_pwdata[23:0];
        REG_GRAVITY_Z:  grav_r[2]    <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BONE_COUNT: cfg_prdata = {27'd0, bone_count_r};
      REG_DRAG_GAIN:  cfg_prdata = {16'd0, drag_gain_r};
      REG_GRAVITY_X:  cfg_prdata = {8'd0, grav_r[0]};
      REG_GRAVITY_Y:  cfg_prdata = {8'd0, grav_r[1]};
      REG_GRAVITY_Z:  cfg_prdata = {8'd0, grav_r[2]};
      default:        cfg_prdata = '0;
    endcase
  end

  // position and rest memories
  assign pm_ra = (st_r == ST_CAP0) ? '0 : bone_r;
  assign rm_a  = BONE_W'(bone_r - BONE_W'(1));

  always_ff @(posedge clk) begin
    if (pm_we) pm[pm_wa] <= pm_wd;
    if (pm_re) pm_q <= pm[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (rm_we) rm[rm_a] <= '{len: len_r, dir: u_r};
    if (rm_re) rm_q <= rm[rm_a];
  end

  // next state and memory controls
  always_comb begin
    st_nxt      = st_r;
    in_ch.ready = 1'b0;
    pm_we = 1'b0;
    pm_wa = bone_r;
    pm_wd = '{cur: nc_r, prv: pm_q.cur};
    pm_re = 1'b0;
    rm_we = 1'b0;
    rm_re = 1'b0;
    emit = 1'b0;
    advance = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        pm_wd = '{cur: {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x},
                  prv: {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x}};
        if (in_ch.valid) begin
          priority case (in_ch.cmd)
            CMD_LOAD: begin
              pm_we = 1'b1;
              pm_wa = in_ch.bone_index;
            end
            CMD_CAPTURE: st_nxt = ST_CAP0;
            CMD_STEP: begin
              pm_we  = 1'b1;
              pm_wa  = '0;
              st_nxt = ST_GRAV;
            end
            default: ;
          endcase
        end
      end
      ST_GRAV: if (ph == 3'd5) st_nxt = ST_RD;
      ST_CAP0: begin
        pm_re  = 1'b1;
        st_nxt = ST_CAP1;
      end
      ST_CAP1: st_nxt = ST_RD;
      ST_RD: begin
        pm_re  = 1'b1;
        rm_re  = 1'b1;
        st_nxt = cap_r ? ST_DIFF : ST_VEL;
      end
      ST_VEL:  if (ph == 3'd3) st_nxt = ST_DIFF;
      ST_DIFF: st_nxt = ST_SQ;
      ST_SQ:   if (ph == 3'd3) st_nxt = ST_SQRT;
      ST_SQRT: if (cnt_r == 6'(SQRT_STEPS - 1)) st_nxt = ST_PICK;
      ST_PICK: begin
        if (len_r > NEAR_ZERO) st_nxt = ST_DIV;
        else st_nxt = cap_r ? ST_WB : ST_CON;
      end
      ST_DIV: if (cnt_r == 6'(DIV_STEPS - 1)) st_nxt = cap_r ? ST_WB : ST_CON;
      ST_CON: if (ph == 3'd3) st_nxt = ST_WB;
      ST_WB: begin
        if (cap_r) begin
          rm_we   = 1'b1;
          advance = 1'b1;
        end else if (out_free) begin
          pm_we   = 1'b1;
          emit    = 1'b1;
          advance = 1'b1;
        end
        if (advance) st_nxt = is_last ? ST_IDLE : ST_RD;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    bone_nxt = bone_r;
    if (st_r == ST_IDLE) bone_nxt = BONE_W'(1);
    else if (advance) bone_nxt = BONE_W'(bone_r + BONE_W'(1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      bone_r      <= BONE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= (st_nxt != st_r) ? '0 : 6'(cnt_r + 6'd1);
      bone_r <= bone_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // shared multiplier operands
  assign vdiff = pm_q.cur[lane] - pm_q.prv[lane];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_GRAV: begin
        if (ph == 3'd0) begin
          mul_a = {18'd0, dt_r};
          mul_b = {18'd0, dt_r};
        end else if (ph >= 3'd2 && ph <= 3'd4) begin
          mul_a = {{10{grav_r[2'(ph - 3'd2)][23]}}, grav_r[2'(ph - 3'd2)]};
          mul_b = {2'd0, dt2_r};
        end
      end
      ST_VEL: if (ph <= 3'd2) begin
        mul_a = {{2{vdiff[31]}}, vdiff};
        mul_b = {18'd0, drag_gain_r};
      end
      ST_SQ: if (ph <= 3'd2) begin
        mul_a = {{2{d_r[lane][31]}}, d_r[lane]};
        mul_b = {{2{d_r[lane][31]}}, d_r[lane]};
      end
      ST_CON: if (ph <= 3'd2) begin
        mul_a = {{16{u_r[lane][17]}}, u_r[lane]};
        mul_b = {2'd0, rm_q.len};
      end
      default: ;
    endcase
  end

  // square root step, two bits a cycle
  always_comb begin
    sq_t = res_r + bit_r;
    if (sv_r >= sq_t) begin
      sv_n  = sv_r - sq_t;
      res_n = (res_r >> 1) + bit_r;
    end else begin
      sv_n  = sv_r;
      res_n = res_r >> 1;
    end
  end

  // restoring divider, three lanes side by side
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_t[k]  = {rem_r[k], num_r[k][47]};
      dv_ge[k] = (dv_t[k] >= {1'b0, len_r});
      rem_n[k] = dv_ge[k] ? 32'(dv_t[k] - {1'b0, len_r}) : dv_t[k][31:0];
      num_n[k] = {num_r[k][46:0], dv_ge[k]};
    end
  end

  assign dsrc = cap_r ? pm_q.cur : nc_r;

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (st_r)
      ST_IDLE: if (in_acc) begin
        par_r <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
        dt_r  <= in_ch.time_step;
        cap_r <= (in_ch.cmd == CMD_CAPTURE);
        if (bone_count_r < 5'd2) n_r <= COUNT_W'(2);
        else if ({1'b0, bone_count_r} > 6'(MAX_BONES)) n_r <= COUNT_W'(MAX_BONES);
        else n_r <= COUNT_W'(bone_count_r);
      end
      ST_GRAV: begin
        if (ph == 3'd1) dt2_r <= prod_r[31:0];
        if (ph >= 3'd3) g_r[2'(ph - 3'd3)] <= prod_r[63:32];
      end
      ST_CAP1: par_r <= pm_q.cur;
      ST_VEL: if (ph >= 3'd1)
        nc_r[plane] <= pm_q.cur[plane] + prod_r[46:15] + g_r[plane];
      ST_DIFF: begin
        for (int k = 0; k < 3; k++) d_r[k] <= dsrc[k] - par_r[k];
        sum_r <= '0;
      end
      ST_SQ: if (ph >= 3'd1) begin
        sum_r <= sum_r + prod_r[63:0];
        if (ph == 3'd3) begin
          sv_r  <= sum_r + prod_r[63:0];
          res_r <= '0;
          bit_r <= 64'h4000_0000_0000_0000;
        end
      end
      ST_SQRT: begin
        sv_r  <= sv_n;
        res_r <= res_n;
        bit_r <= bit_r >> 2;
        if (cnt_r == 6'(SQRT_STEPS - 1)) len_r <= res_n[31:0];
      end
      ST_PICK: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= d_r[k][31];
          num_r[k] <= {(d_r[k][31] ? 32'(-d_r[k]) : d_r[k]), 16'd0};
          rem_r[k] <= '0;
        end
        if (cap_r) u_r <= {18'd0, MONE_Q16, 18'd0};
        else u_r <= rm_q.dir;
      end
      ST_DIV: begin
        num_r <= num_n;
        rem_r <= rem_n;
        if (cnt_r == 6'(DIV_STEPS - 1))
          for (int k = 0; k < 3; k++)
            u_r[k] <= neg_r[k] ? 18'(-num_n[k][17:0]) : num_n[k][17:0];
      end
      ST_CON: if (ph >= 3'd1) nc_r[plane] <= par_r[plane] + prod_r[47:16];
      ST_WB: begin
        if (cap_r) par_r <= pm_q.cur;
        else if (emit) par_r <= nc_r;
      end
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= bone_r;
      out_pos_r  <= nc_r;
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bone_index_res = out_idx_r;
  assign out_ch.out_x          = out_pos_r[0];
  assign out_ch.out_y          = out_pos_r[1];
  assign out_ch.out_z          = out_pos_r[2];
  assign out_ch.last           = out_last_r;

  // checks
  a_emit_bone: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (bone_r != '0) && ({1'b0, bone_r} < n_r))
    else $error("result for a bone outside the chain");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ch.ready))
    else $error("output word overwritten before it was taken");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (len_r > NEAR_ZERO))
    else $error("divider started on a short link");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.cmd == CMD_STEP) |=> (st_r == ST_GRAV))
    else $error("step command did not start the gravity phase");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for spring_bone_chain_step: loads, captures and steps
// are driven with random gaps, a software chain model predicts every bone
// word, and each word from the block is compared field by field.
// ----------------------------------------------------------------------------

module tb_top;
  import sbc_pkg::*;

  localparam logic [1:0] CMD_NOP   = 2'd3;
  localparam int         SETTLE    = 2500;
  localparam int         MAX_CYCLE = 4000000;

  typedef struct {
    logic [3:0]  bone;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } bone_word_t;

  // chain model and queue of bone words still owed by the block
  class chain_scoreboard;
    bone_word_t  owed[$];
    int          errors;
    logic [4:0]  n_bones;
    logic [15:0] drag;
    logic [23:0] grav[3];
    logic [31:0] cur[16][3];
    logic [31:0] prv[16][3];
    logic [31:0] rest_len[15];
    longint      rest_dir[15][3];

    function new();
      errors  = 0;
      n_bones = BONE_COUNT_RST;
      drag    = DRAG_GAIN_RST;
      grav[0] = '0;
      grav[1] = GRAVITY_Y_RST;
      grav[2] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_BONE_COUNT: n_bones = val[4:0];
        REG_DRAG_GAIN:  drag = val[15:0];
        REG_GRAVITY_X:  grav[0] = val[23:0];
        REG_GRAVITY_Y:  grav[1] = val[23:0];
        REG_GRAVITY_Z:  grav[2] = val[23:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res[31:0];
    endfunction

    // wrapped link vector child - parent and its length
    function logic [31:0] link_len(int child, int parent, output longint d[3]);
      longint unsigned sum;
      logic [31:0] diff;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        diff = cur[child][k] - cur[parent][k];
        d[k] = longint'($signed(diff));
        sum = sum + longint'(d[k] * d[k]);
      end
      return int_root(sum);
    endfunction

    function int chain_n();
      if (n_bones < 2) return 2;
      if (n_bones > 16) return 16;
      return int'(n_bones);
    endfunction

    function void note_input(logic [1:0] cmd, logic [3:0] idx, logic [31:0] p[3],
                             logic [15:0] dt);
      int n;
      longint d[3];
      longint u[3];
      longint dt2, vel;
      logic [31:0] len, gstep[3], diff;
      bone_word_t w;
      n = chain_n();
      case (cmd)
        CMD_LOAD: begin
          for (int k = 0; k < 3; k++) begin
            cur[idx][k] = p[k];
            prv[idx][k] = p[k];
          end
        end
        CMD_CAPTURE: begin
          for (int i = 0; i < n - 1; i++) begin
            len = link_len(i + 1, i, d);
            rest_len[i] = len;
            for (int k = 0; k < 3; k++) begin
              if (len > NEAR_ZERO) rest_dir[i][k] = (d[k] * 65536) / longint'(len);
              else rest_dir[i][k] = (k == 1) ? -65536 : 0;
            end
          end
        end
        CMD_STEP: begin
          dt2 = longint'(dt) * longint'(dt);
          for (int k = 0; k < 3; k++) begin
            gstep[k] = 32'((longint'($signed(grav[k])) * dt2) >>> 32);
            cur[0][k] = p[k];
            prv[0][k] = p[k];
          end
          // verlet move with drag and gravity
          for (int i = 1; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
              diff = cur[i][k] - prv[i][k];
              vel = (longint'($signed(diff)) * longint'(drag)) >>> 15;
              prv[i][k] = cur[i][k];
              cur[i][k] = cur[i][k] + vel[31:0] + gstep[k];
            end
          end
          // length fix from the root outward
          for (int i = 1; i < n; i++) begin
            len = link_len(i, i - 1, d);
            for (int k = 0; k < 3; k++) begin
              if (len > NEAR_ZERO) u[k] = (d[k] * 65536) / longint'(len);
              else u[k] = rest_dir[i - 1][k];
              vel = (u[k] * longint'(rest_len[i - 1])) >>> 16;
              cur[i][k] = cur[i - 1][k] + vel[31:0];
            end
            w.bone = i[3:0];
            w.x = cur[i][0];
            w.y = cur[i][1];
            w.z = cur[i][2];
            w.last = (i == n - 1);
            owed.push_back(w);
          end
        end
        default: ;
      endcase
    endfunction

    function void check(bone_word_t got);
      bone_word_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected bone word, bone %0d x %h y %h z %h last %b",
                 $time, got.bone, got.x, got.y, got.z, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.bone !== want.bone) begin
        $display("%0t: bone index expected %0d actual %0d", $time, want.bone, got.bone);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: bone %0d x expected %h actual %h", $time, want.bone, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: bone %0d y expected %h actual %h", $time, want.bone, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: bone %0d z expected %h actual %h", $time, want.bone, want.z, got.z);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: bone %0d last expected %b actual %b", $time, want.bone,
                 want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sbc_in_if  in_if();
  sbc_out_if out_if();

  chain_scoreboard sb;
  bit  quiet;
  int  out_stall;
  int  cycles;
  int  fed;

  spring_bone_chain_step dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    bone_word_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.bone = out_if.bone_index_res;
      got.x = out_if.out_x;
      got.y = out_if.out_y;
      got.z = out_if.out_z;
      got.last = out_if.last;
      sb.check(got);
    end
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!quiet) out_stall <= pick_gap();
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // send one command word, wait for its handshake, then maybe idle
  task automatic send(logic [1:0] cmd, logic [3:0] idx, logic [31:0] px,
                      logic [31:0] py, logic [31:0] pz, logic [15:0] dt);
    logic [31:0] p[3];
    int gap;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.bone_index <= idx;
    in_if.pos_x      <= px;
    in_if.pos_y      <= py;
    in_if.pos_z      <= pz;
    in_if.time_step  <= dt;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(cmd, idx, p, dt);
    if (cmd != CMD_NOP) fed++;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block idle: all words back and any silent command finished
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    return 32'($urandom_range(0, 1 << 21) - (1 << 20));
  endfunction

  function automatic logic [31:0] rnd_ofs();
    return 32'($urandom_range(0, 1 << 19) - (1 << 18));
  endfunction

  // a loaded chain near a random base, a capture, then a few steps
  task automatic chain_run();
    int n;
    logic [31:0] b[3];
    n = sb.chain_n();
    for (int k = 0; k < 3; k++) b[k] = rnd_coord();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0 && i > 0)
        send(CMD_LOAD, i[3:0], b[0], b[1], b[2], 16'($urandom));
      else begin
        for (int k = 0; k < 3; k++) b[k] = b[k] + rnd_ofs();
        send(CMD_LOAD, i[3:0], b[0], b[1], b[2], 16'($urandom));
      end
    end
    send(CMD_CAPTURE, 4'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
    repeat ($urandom_range(2, 6)) begin
      for (int k = 0; k < 3; k++) b[k] = b[k] + rnd_ofs();
      send(CMD_STEP, 4'($urandom), b[0], b[1], b[2], 16'($urandom));
    end
  endtask

  task automatic random_cfg();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: cfg_write(REG_BONE_COUNT, 32'd0);
      1: cfg_write(REG_BONE_COUNT, 32'd31);
      2: cfg_write(REG_BONE_COUNT, 32'd16);
      3: cfg_write(REG_BONE_COUNT, 32'd2);
      default: cfg_write(REG_BONE_COUNT, $urandom_range(1, 17));
    endcase
    r = $urandom_range(0, 3);
    cfg_write(REG_DRAG_GAIN, r == 0 ? 32'd0 : r == 1 ? 32'd32768 :
              r == 2 ? 32'd65535 : $urandom_range(0, 32768));
    for (int k = 0; k < 3; k++) begin
      r = $urandom_range(0, 3);
      cfg_write(REG_GRAVITY_X + k[2:0], r == 0 ? 32'h800000 : r == 1 ? 32'h7fffff :
                $urandom & 32'hffffff);
    end
  endtask

  initial begin
    sb = new();
    rst_n        = 1'b0;
    quiet        = 1'b0;
    out_stall    = 0;
    cycles       = 0;
    fed          = 0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_LOAD;
    in_if.bone_index = '0;
    in_if.pos_x  = '0;
    in_if.pos_y  = '0;
    in_if.pos_z  = '0;
    in_if.time_step = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full chain so every rest entry is written once
    cfg_write(REG_BONE_COUNT, 32'd16);
    for (int i = 0; i < 16; i++) begin
      if (i == 2) send(CMD_LOAD, 4'd2, 32'h0001_0000, 32'hffff_0000, 32'h0, 16'hffff);
      else send(CMD_LOAD, i[3:0], i * 32'h0001_0000, -i * 32'h0001_0000,
                i[0] ? 32'hffff_ffff : 32'h0, 16'h0);
    end
    // bones 1 and 2 lie one LSB apart: fallback rest direction
    send(CMD_CAPTURE, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    send(CMD_STEP, 4'h0, 32'h0, 32'h0, 32'h0, 16'h0);
    send(CMD_STEP, 4'hf, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
    send(CMD_NOP, 4'h5, 32'h1234_5678, 32'h0, 32'h0, 16'h1);
    send(CMD_STEP, 4'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h8000);
    drain();
    cfg_write(REG_DRAG_GAIN, 32'd65535);
    cfg_write(REG_GRAVITY_X, 32'h7fffff);
    cfg_write(REG_GRAVITY_Y, 32'h800000);
    cfg_write(REG_GRAVITY_Z, 32'h7fffff);
    cfg_write(REG_BONE_COUNT, 32'd1);
    send(CMD_STEP, 4'h3, 32'h0, 32'h0, 32'h0, 16'hffff);
    drain();
    cfg_write(REG_BONE_COUNT, 32'd31);
    send(CMD_STEP, 4'h3, 32'h10, 32'h20, 32'h30, 16'h1234);

    // random phases
    while (fed < 300) begin
      drain();
      random_cfg();
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 3) != 0) chain_run();
        else begin
          repeat ($urandom_range(1, 4))
            send(2'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                 16'($urandom));
        end
      end
    end
    quiet = 1'b0;

    in_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
